// ----- rtl/antialiased_line_pixel_blend_defines.svh -----
// assertion macros for the antialiased line pixel blend
// expects clk and rst_n in the scope of every use
`ifndef ANTIALIASED_LINE_PIXEL_BLEND_DEFINES_SVH
`define ANTIALIASED_LINE_PIXEL_BLEND_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ALPB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pixel blend assertion failed");
// next-cycle implication
`define ALPB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pixel blend assertion failed");
`else
`define ALPB_ASSERT_IMP(lbl, ante, cons)
`define ALPB_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/alpb_pkg.sv -----
// shared types, constants and helpers for the antialiased line pixel blend
// no dependencies
package alpb_pkg;

  localparam int COORD_W    = 20;
  localparam int HW_W       = 16;
  localparam int RGB_W      = 24;
  localparam int ALPHA_W    = 8;
  localparam int PIX_W      = 32;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int T_FRAC     = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X,
    CFG_START_Y,
    CFG_END_X,
    CFG_END_Y,
    CFG_HALF_WIDTH,
    CFG_STROKE_RGB,
    CFG_STROKE_ALPHA
  } cfg_idx_t;

  // pipeline control handed to the arithmetic units
  typedef struct packed {
    logic valid;
    logic advance;
  } pipe_ctl_t;

  // floor(v / 255) for v below 65280
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] s;
    s = 17'(v) + 17'd1 + 17'(v >> 8);
    return s[15:8];
  endfunction

endpackage

// ----- rtl/alpb_div.sv -----
// pipelined restoring divider, one quotient bit per stage, numerator below divisor
// depends on alpb_pkg
module alpb_div #(
  parameter int DVW  = 42,
  parameter int QW   = 16,
  parameter int SB_W = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  alpb_pkg::pipe_ctl_t ctl,
  input  logic [DVW-1:0]      num,
  input  logic [DVW-1:0]      den,
  input  logic [SB_W-1:0]     sb_in,
  output logic                out_valid,
  output logic [QW-1:0]       quot,
  output logic [SB_W-1:0]     sb_out
);
  import alpb_pkg::*;

  logic [DVW-1:0]  rem_r [QW];
  logic [DVW-1:0]  den_r [QW];
  logic [QW-1:0]   q_r   [QW];
  logic [SB_W-1:0] sb_r  [QW];
  logic            v_r   [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DVW-1:0]  rem_prev;
    logic [DVW-1:0]  den_prev;
    logic [QW-1:0]   q_prev;
    logic [SB_W-1:0] sb_prev;
    logic            v_prev;
    logic [DVW:0]    dbl;
    logic [DVW:0]    diff;
    logic            ge;

    if (i == 0) begin : g_first
      assign rem_prev = num;
      assign den_prev = den;
      assign q_prev   = '0;
      assign sb_prev  = sb_in;
      assign v_prev   = ctl.valid;
    end else begin : g_rest
      assign rem_prev = rem_r[i-1];
      assign den_prev = den_r[i-1];
      assign q_prev   = q_r[i-1];
      assign sb_prev  = sb_r[i-1];
      assign v_prev   = v_r[i-1];
    end

    assign dbl  = {rem_prev, 1'b0};
    assign ge   = dbl >= {1'b0, den_prev};
    assign diff = dbl - {1'b0, den_prev};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (ctl.advance) begin
        v_r[i] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.advance) begin
        rem_r[i] <= ge ? diff[DVW-1:0] : dbl[DVW-1:0];
        den_r[i] <= den_prev;
        q_r[i]   <= {q_prev[QW-2:0], ge};
        sb_r[i]  <= sb_prev;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign quot      = q_r[QW-1];
  assign sb_out    = sb_r[QW-1];

endmodule

// ----- rtl/alpb_sqrt.sv -----
// pipelined integer square root, one root bit per stage
// depends on alpb_pkg
module alpb_sqrt #(
  parameter int RB   = 24,
  parameter int SB_W = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  alpb_pkg::pipe_ctl_t ctl,
  input  logic [2*RB-1:0]     radicand,
  input  logic [SB_W-1:0]     sb_in,
  output logic                out_valid,
  output logic [RB-1:0]       root,
  output logic [SB_W-1:0]     sb_out
);
  import alpb_pkg::*;

  localparam int RMW = RB + 2;

  logic [2*RB-1:0] rad_r  [RB];
  logic [RMW-1:0]  rem_r  [RB];
  logic [RB-1:0]   root_r [RB];
  logic [SB_W-1:0] sb_r   [RB];
  logic            v_r    [RB];

  for (genvar i = 0; i < RB; i++) begin : g_stage
    logic [2*RB-1:0] rad_prev;
    logic [RMW-1:0]  rem_prev;
    logic [RB-1:0]   root_prev;
    logic [SB_W-1:0] sb_prev;
    logic            v_prev;
    logic [RMW+1:0]  cur;
    logic [RMW+1:0]  trial;
    logic [RMW+1:0]  diff;
    logic            ge;

    if (i == 0) begin : g_first
      assign rad_prev  = radicand;
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign sb_prev   = sb_in;
      assign v_prev    = ctl.valid;
    end else begin : g_rest
      assign rad_prev  = rad_r[i-1];
      assign rem_prev  = rem_r[i-1];
      assign root_prev = root_r[i-1];
      assign sb_prev   = sb_r[i-1];
      assign v_prev    = v_r[i-1];
    end

    // bring down the next two radicand bits, try root*4 + 1
    assign cur   = {rem_prev, rad_prev[2*RB-1:2*RB-2]};
    assign trial = (RMW+2)'({root_prev, 2'b01});
    assign ge    = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (ctl.advance) begin
        v_r[i] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.advance) begin
        rad_r[i]  <= rad_prev << 2;
        rem_r[i]  <= ge ? diff[RMW-1:0] : cur[RMW-1:0];
        root_r[i] <= {root_prev[RB-2:0], ge};
        sb_r[i]   <= sb_prev;
      end
    end
  end

  assign out_valid = v_r[RB-1];
  assign root      = root_r[RB-1];
  assign sb_out    = sb_r[RB-1];

endmodule

// ----- rtl/antialiased_line_pixel_blend.sv -----
// top level of the antialiased line pixel blend: config registers and main pipeline
// depends on alpb_pkg, alpb_div, alpb_sqrt and antialiased_line_pixel_blend_defines.svh
//
//   channel   ports                                         role
//   in        in_valid/in_ready, in_pixel_x/y, in_dest_pixel  pixel to evaluate
//   out       out_valid/out_ready, out_x/y, out_pixel_out,    blended pixel
//             out_changed
//   cfg       cfg_we, cfg_index, cfg_data                     register write, no wait
//
// one transaction per clock when out_ready stays high
// RB = max(pixel + fraction bits, 20) + 3 is the distance width;
//   16 divider stages and RB square root stages make up most of the pipe
// one global advance moves every stage; a stall at the output freezes the whole pipe
// synchronous active-low reset clears valid bits and config registers
`include "antialiased_line_pixel_blend_defines.svh"

module antialiased_line_pixel_blend #(
  parameter int COORD_FRAC_BITS  = 8,
  parameter int PIXEL_COORD_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [PIXEL_COORD_BITS-1:0]      in_pixel_x,
  input  logic [PIXEL_COORD_BITS-1:0]      in_pixel_y,
  input  logic [alpb_pkg::PIX_W-1:0]       in_dest_pixel,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [PIXEL_COORD_BITS-1:0]      out_x,
  output logic [PIXEL_COORD_BITS-1:0]      out_y,
  output logic [alpb_pkg::PIX_W-1:0]       out_pixel_out,
  output logic                             out_changed,
  input  logic                             cfg_we,
  input  logic [alpb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [alpb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import alpb_pkg::*;

  localparam int F    = COORD_FRAC_BITS;
  localparam int P    = PIXEL_COORD_BITS;
  localparam int ONE  = 1 << F;
  localparam int HALF = 1 << (F - 1);
  // relative pixel centre width, sign and carry included
  localparam int RW   = ((P + F > COORD_W) ? P + F : COORD_W) + 2;
  localparam int DW   = COORD_W + 1;      // segment delta
  localparam int PW   = RW + DW;          // one dot product term
  localparam int DOTW = PW + 1;
  localparam int L2W  = 2 * DW;           // squared length
  localparam int TW   = T_FRAC + 1;       // t, 0 .. 1.0
  localparam int TPW  = TW + 1 + DW;      // t times delta
  localparam int EW   = RW + 1;           // offset to closest point
  localparam int SW   = 2 * EW;           // squared distance
  localparam int RB   = EW;               // distance bits
  localparam int CW   = RB + 2;           // coverage, signed
  localparam int AW   = ALPHA_W + F + 1;
  localparam longint THR = (64'd1 << (2 * F)) / 10000;
  localparam logic [F:0] ONE_C = {1'b1, {F{1'b0}}};

  typedef struct packed {
    logic [P-1:0]     x;
    logic [P-1:0]     y;
    logic [PIX_W-1:0] dest;
    logic             live;
  } item_t;

  typedef struct packed {
    item_t                 it;
    logic                  tz;
    logic                  tf;
    logic signed [RW-1:0]  rx;
    logic signed [RW-1:0]  ry;
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
  } div_sb_t;

  // config registers
  logic [COORD_W-1:0] start_x_r, start_y_r, end_x_r, end_y_r;
  logic [HW_W-1:0]    half_width_r;
  logic [RGB_W-1:0]   stroke_rgb_r;
  logic [ALPHA_W-1:0] stroke_alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r      <= '0;
      start_y_r      <= '0;
      end_x_r        <= '0;
      end_y_r        <= '0;
      half_width_r   <= '0;
      stroke_rgb_r   <= '0;
      stroke_alpha_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_START_X:      start_x_r      <= cfg_data[COORD_W-1:0];
        CFG_START_Y:      start_y_r      <= cfg_data[COORD_W-1:0];
        CFG_END_X:        end_x_r        <= cfg_data[COORD_W-1:0];
        CFG_END_Y:        end_y_r        <= cfg_data[COORD_W-1:0];
        CFG_HALF_WIDTH:   half_width_r   <= cfg_data[HW_W-1:0];
        CFG_STROKE_RGB:   stroke_rgb_r   <= cfg_data[RGB_W-1:0];
        CFG_STROKE_ALPHA: stroke_alpha_r <= cfg_data[ALPHA_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // global advance: the output register is free or being drained
  logic out_valid_r;
  logic adv;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // stage 1: pixel centre relative to start, segment delta
  logic                 v1_r;
  item_t                it1_r, it1_nxt;
  logic signed [RW-1:0] rx1_r, ry1_r, rx1_nxt, ry1_nxt;
  logic signed [DW-1:0] dx1_r, dy1_r, dx1_nxt, dy1_nxt;

  always_comb begin
    it1_nxt.x    = in_pixel_x;
    it1_nxt.y    = in_pixel_y;
    it1_nxt.dest = in_dest_pixel;
    // a zero alpha or zero width disables the stroke outright
    it1_nxt.live = (stroke_alpha_r != '0) && (half_width_r != '0);
    rx1_nxt = $signed(RW'({in_pixel_x, {F{1'b0}}})) + RW'(HALF)
              - RW'($signed(start_x_r));
    ry1_nxt = $signed(RW'({in_pixel_y, {F{1'b0}}})) + RW'(HALF)
              - RW'($signed(start_y_r));
    dx1_nxt = DW'($signed(end_x_r)) - DW'($signed(start_x_r));
    dy1_nxt = DW'($signed(end_y_r)) - DW'($signed(start_y_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it1_r <= it1_nxt;
      rx1_r <= rx1_nxt;
      ry1_r <= ry1_nxt;
      dx1_r <= dx1_nxt;
      dy1_r <= dy1_nxt;
    end
  end

  // stage 2: dot product terms and squared length terms
  logic                  v2_r;
  item_t                 it2_r;
  logic signed [PW-1:0]  pdx2_r, pdy2_r;
  logic signed [L2W-1:0] qdx2_r, qdy2_r;
  logic signed [RW-1:0]  rx2_r, ry2_r;
  logic signed [DW-1:0]  dx2_r, dy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it2_r  <= it1_r;
      pdx2_r <= PW'(rx1_r) * PW'(dx1_r);
      pdy2_r <= PW'(ry1_r) * PW'(dy1_r);
      qdx2_r <= L2W'(dx1_r) * L2W'(dx1_r);
      qdy2_r <= L2W'(dy1_r) * L2W'(dy1_r);
      rx2_r  <= rx1_r;
      ry2_r  <= ry1_r;
      dx2_r  <= dx1_r;
      dy2_r  <= dy1_r;
    end
  end

  // stage 3: dot, squared length, clamp cases for t
  logic                   v3_r;
  div_sb_t                sb3_r, sb3_nxt;
  logic [L2W-1:0]         num3_r, len3_r;
  logic signed [DOTW-1:0] dot3;
  logic [L2W-1:0]         len2_3;

  always_comb begin
    dot3    = DOTW'(pdx2_r) + DOTW'(pdy2_r);
    len2_3  = $unsigned(qdx2_r) + $unsigned(qdy2_r);
    sb3_nxt.it = it2_r;
    // degenerate segment (squared length at most 0.0001) leaves the pixel alone
    sb3_nxt.it.live = it2_r.live && (len2_3 > L2W'(THR));
    sb3_nxt.tz = dot3 <= 0;
    sb3_nxt.tf = !(dot3 <= 0) && ($unsigned(dot3) >= DOTW'(len2_3));
    sb3_nxt.rx = rx2_r;
    sb3_nxt.ry = ry2_r;
    sb3_nxt.dx = dx2_r;
    sb3_nxt.dy = dy2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb3_r  <= sb3_nxt;
      // only the interior case divides; clamp cases feed a zero numerator
      num3_r <= (sb3_nxt.tz || sb3_nxt.tf) ? '0 : dot3[L2W-1:0];
      len3_r <= len2_3;
    end
  end

  // t = dot * 2^16 / len2
  pipe_ctl_t          div_ctl;
  logic               vd;
  logic [T_FRAC-1:0]  quot_d;
  logic [$bits(div_sb_t)-1:0] sbd_vec;
  div_sb_t            sbd;

  assign div_ctl.valid   = v3_r;
  assign div_ctl.advance = adv;
  assign sbd             = div_sb_t'(sbd_vec);

  alpb_div #(
    .DVW  (L2W),
    .QW   (T_FRAC),
    .SB_W ($bits(div_sb_t))
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .num       (num3_r),
    .den       (len3_r),
    .sb_in     (sb3_r),
    .out_valid (vd),
    .quot      (quot_d),
    .sb_out    (sbd_vec)
  );

  // stage 4: t times delta
  logic                  v4_r;
  item_t                 it4_r;
  logic signed [TPW-1:0] ptx4_r, pty4_r;
  logic signed [RW-1:0]  rx4_r, ry4_r;
  logic [TW-1:0]         t4;
  logic signed [TPW-1:0] t4_s;

  always_comb begin
    if (sbd.tz) begin
      t4 = '0;
    end else if (sbd.tf) begin
      t4 = {1'b1, {T_FRAC{1'b0}}};
    end else begin
      t4 = TW'(quot_d);
    end
    t4_s = $signed(TPW'(t4));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it4_r  <= sbd.it;
      ptx4_r <= t4_s * TPW'(sbd.dx);
      pty4_r <= t4_s * TPW'(sbd.dy);
      rx4_r  <= sbd.rx;
      ry4_r  <= sbd.ry;
    end
  end

  // stage 5: round half away from zero, offset to closest point
  logic                 v5_r;
  item_t                it5_r;
  logic signed [EW-1:0] ex5_r, ey5_r, ex5_nxt, ey5_nxt;
  logic [TPW-1:0]       magx, magy, rndx, rndy;
  logic signed [EW-1:0] offx, offy;

  always_comb begin
    magx = ptx4_r[TPW-1] ? $unsigned(-ptx4_r) : $unsigned(ptx4_r);
    magy = pty4_r[TPW-1] ? $unsigned(-pty4_r) : $unsigned(pty4_r);
    rndx = (magx + TPW'(1 << (T_FRAC - 1))) >> T_FRAC;
    rndy = (magy + TPW'(1 << (T_FRAC - 1))) >> T_FRAC;
    offx = ptx4_r[TPW-1] ? -$signed(EW'(rndx)) : $signed(EW'(rndx));
    offy = pty4_r[TPW-1] ? -$signed(EW'(rndy)) : $signed(EW'(rndy));
    ex5_nxt = EW'(rx4_r) - offx;
    ey5_nxt = EW'(ry4_r) - offy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it5_r <= it4_r;
      ex5_r <= ex5_nxt;
      ey5_r <= ey5_nxt;
    end
  end

  // stage 6: squares
  logic                 v6_r;
  item_t                it6_r;
  logic signed [SW-1:0] sqx6_r, sqy6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (adv) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it6_r  <= it5_r;
      sqx6_r <= SW'(ex5_r) * SW'(ex5_r);
      sqy6_r <= SW'(ey5_r) * SW'(ey5_r);
    end
  end

  // stage 7: squared distance
  logic          v7_r;
  item_t         it7_r;
  logic [SW-1:0] d2_7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (adv) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it7_r  <= it6_r;
      d2_7_r <= $unsigned(sqx6_r) + $unsigned(sqy6_r);
    end
  end

  // distance = floor(sqrt(d2))
  pipe_ctl_t                sq_ctl;
  logic                     vs;
  logic [RB-1:0]            dist_s;
  logic [$bits(item_t)-1:0] its_vec;
  item_t                    its;

  assign sq_ctl.valid   = v7_r;
  assign sq_ctl.advance = adv;
  assign its            = item_t'(its_vec);

  alpb_sqrt #(
    .RB   (RB),
    .SB_W ($bits(item_t))
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (sq_ctl),
    .radicand  (d2_7_r),
    .sb_in     (it7_r),
    .out_valid (vs),
    .root      (dist_s),
    .sb_out    (its_vec)
  );

  // stage 8: coverage, clamped to 0..1
  logic                 v8_r;
  item_t                it8_r, it8_nxt;
  logic [F:0]           cov8_r, cov8_nxt;
  logic [HW_W-1:0]      hwc;
  logic signed [CW-1:0] cov;

  always_comb begin
    // half width below one half pixel is raised to one half
    hwc = (half_width_r < HW_W'(HALF)) ? HW_W'(HALF) : half_width_r;
    cov = $signed(CW'(hwc)) + CW'(ONE) - $signed(CW'(dist_s));
    it8_nxt      = its;
    it8_nxt.live = its.live && (cov > 0);
    cov8_nxt     = (cov > CW'(ONE)) ? ONE_C : cov[F:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (adv) begin
      v8_r <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it8_r  <= it8_nxt;
      cov8_r <= cov8_nxt;
    end
  end

  // stage 9: source alpha = stroke alpha * coverage, rounded
  logic               v9_r;
  item_t              it9_r, it9_nxt;
  logic [ALPHA_W-1:0] a9_r, a9_nxt;
  logic [AW-1:0]      aprod;

  always_comb begin
    aprod   = AW'(stroke_alpha_r) * AW'(cov8_r) + AW'(HALF);
    a9_nxt  = aprod[F+ALPHA_W-1:F];
    it9_nxt = it8_r;
    // coverage that rounds to zero alpha passes the pixel
    it9_nxt.live = it8_r.live && (a9_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else if (adv) begin
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it9_r <= it9_nxt;
      a9_r  <= a9_nxt;
    end
  end

  // stage 10: blend products per lane, lane 3 is alpha with a source of 255
  logic        v10_r;
  item_t       it10_r;
  logic [15:0] ps10_r [4];
  logic [15:0] pd10_r [4];
  logic [7:0]  src10 [4];
  logic [7:0]  inv_a;

  always_comb begin
    src10[0] = stroke_rgb_r[7:0];
    src10[1] = stroke_rgb_r[15:8];
    src10[2] = stroke_rgb_r[23:16];
    src10[3] = 8'hFF;
    inv_a    = 8'hFF - a9_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
    end else if (adv) begin
      v10_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it10_r <= it9_r;
      for (int k = 0; k < 4; k++) begin
        ps10_r[k] <= 16'(src10[k]) * 16'(a9_r);
        pd10_r[k] <= 16'(it9_r.dest[8*k +: 8]) * 16'(inv_a);
      end
    end
  end

  // output stage: divide by 255 with rounding, sum, saturate
  logic [PIX_W-1:0] blend;
  logic [8:0]       lane_sum [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lane_sum[k] = 9'(div255(ps10_r[k] + 16'd127)) + 9'(div255(pd10_r[k] + 16'd127));
      blend[8*k +: 8] = lane_sum[k][8] ? 8'hFF : lane_sum[k][7:0];
    end
  end

  logic [P-1:0]     out_x_r, out_y_r;
  logic [PIX_W-1:0] out_pixel_r;
  logic             out_changed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v10_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r       <= it10_r.x;
      out_y_r       <= it10_r.y;
      out_pixel_r   <= it10_r.live ? blend : it10_r.dest;
      out_changed_r <= it10_r.live;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_x         = out_x_r;
  assign out_y         = out_y_r;
  assign out_pixel_out = out_pixel_r;
  assign out_changed   = out_changed_r;

  // a touched pixel always ends with nonzero alpha
  `ALPB_ASSERT_IMP(a_changed_alpha, out_valid && out_changed, out_pixel_out[31:24] != 8'd0)
  // disabled stroke never changes a pixel
  `ALPB_ASSERT_IMP(a_off_alpha, out_valid && (stroke_alpha_r == '0), !out_changed)
  `ALPB_ASSERT_IMP(a_off_width, out_valid && (half_width_r == '0), !out_changed)
  // an accepted transaction lands in the first stage
  `ALPB_ASSERT_NXT(a_enter, in_valid && in_ready, v1_r)

endmodule

// ----- test/tb.sv -----
// testbench for antialiased_line_pixel_blend: random and directed pixels against a predictor
// depends on alpb_pkg and the rtl of antialiased_line_pixel_blend
`timescale 1ns / 100ps

module tb;
  import alpb_pkg::*;

  localparam int FB = 8;   // coordinate fraction bits
  localparam int PB = 12;  // pixel coordinate bits
  localparam int LAT = 80; // generous margin over the pipe
  localparam longint LIMIT = 400000;

  typedef struct packed {
    logic [PB-1:0] x;
    logic [PB-1:0] y;
    logic [31:0]   pix;
  } pixel_t;

  typedef struct packed {
    logic [PB-1:0] x;
    logic [PB-1:0] y;
    logic [31:0]   pix;
    logic          changed;
  } blend_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready;
  logic [PB-1:0] in_pixel_x = '0, in_pixel_y = '0;
  logic [31:0] in_dest_pixel = '0;
  logic out_valid, out_ready = 0, out_changed;
  logic [PB-1:0] out_x, out_y;
  logic [31:0] out_pixel_out;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  antialiased_line_pixel_blend uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // shadow copy of the line and stroke registers
  logic [19:0] sh_sx, sh_sy, sh_ex, sh_ey;
  logic [15:0] sh_hw;
  logic [23:0] sh_rgb;
  logic [7:0]  sh_alpha;

  pixel_t pending_pixels[$];
  blend_t expected_blends[$];
  int errors = 0;
  longint cycles = 0;
  bit stim_done = 0;

  function automatic longint isqrt(longint unsigned n);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint rnd16(longint p);
    if (p >= 0) return (p + 32768) >>> 16;
    return -((-p + 32768) >>> 16);
  endfunction

  function automatic int unsigned over(int unsigned s, int unsigned a, int unsigned d);
    int unsigned v;
    v = (s * a + 127) / 255 + (d * (255 - a) + 127) / 255;
    return v > 255 ? 255 : v;
  endfunction

  // coverage of the pixel by the stroke and the source-over result
  function automatic blend_t predict_blend(pixel_t p);
    blend_t r;
    longint x1, y1, dx, dy, hw, rx, ry, dot, t, ex, ey, cov;
    longint unsigned len2, dist_v;
    int unsigned a, da;
    r.x = p.x; r.y = p.y; r.pix = p.pix; r.changed = 0;
    if (sh_alpha == 0 || sh_hw == 0) return r;
    x1 = longint'(signed'(sh_sx)); y1 = longint'(signed'(sh_sy));
    dx = longint'(signed'(sh_ex)) - x1; dy = longint'(signed'(sh_ey)) - y1;
    len2 = dx * dx + dy * dy;
    hw = sh_hw < (1 << (FB - 1)) ? (1 << (FB - 1)) : sh_hw;
    if (len2 * 10000 <= (64'd1 << (2 * FB))) return r;  // degenerate line
    rx = (longint'(p.x) << FB) + (1 << (FB - 1)) - x1;
    ry = (longint'(p.y) << FB) + (1 << (FB - 1)) - y1;
    dot = rx * dx + ry * dy;
    if (dot <= 0) t = 0;
    else if (unsigned'(dot) >= len2) t = 65536;
    else t = longint'((unsigned'(dot) << 16) / len2);
    ex = rx - rnd16(t * dx);
    ey = ry - rnd16(t * dy);
    dist_v = isqrt(ex * ex + ey * ey);
    cov = hw + (1 << FB) - longint'(dist_v);
    if (cov <= 0) return r;
    if (cov > (1 << FB)) cov = 1 << FB;
    a = (sh_alpha * cov + (1 << (FB - 1))) >> FB;
    if (a == 0) return r;
    da = a + (p.pix[31:24] * (255 - a) + 127) / 255;
    if (da > 255) da = 255;
    r.pix = {8'(da), 8'(over(sh_rgb[23:16], a, p.pix[23:16])),
             8'(over(sh_rgb[15:8], a, p.pix[15:8])), 8'(over(sh_rgb[7:0], a, p.pix[7:0]))};
    r.changed = 1;
    return r;
  endfunction

  // driver: bursts of transactions with random gaps, expectation stored at acceptance
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_valid && in_ready) expected_blends.push_back(predict_blend(
          '{x: in_pixel_x, y: in_pixel_y, pix: in_dest_pixel}));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 0;
        end else if (pending_pixels.size() > 0) begin
          pixel_t p;
          p = pending_pixels.pop_front();
          in_valid <= 1;
          in_pixel_x <= p.x; in_pixel_y <= p.y; in_dest_pixel <= p.pix;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end else burst_left <= burst_left - 1;
        end else in_valid <= 0;
      end
    end
  end

  // monitor: receiver stalls in its own on/off pattern
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      stall_phase <= stall_phase + 1;
      out_ready <= (stall_phase[6:5] == 2'b11) ? 1'b1 : ($urandom_range(0, 3) != 0);
      if (out_valid && out_ready) begin
        if (expected_blends.size() == 0) begin
          $display("%0t unexpected transaction x=%0d y=%0d", $time, out_x, out_y);
          errors <= errors + 1;
        end else begin
          blend_t e;
          e = expected_blends.pop_front();
          if (e != {out_x, out_y, out_pixel_out, out_changed}) begin
            $display("%0t expected x=%0d y=%0d pix=%h ch=%b actual x=%0d y=%0d pix=%h ch=%b",
                     $time, e.x, e.y, e.pix, e.changed,
                     out_x, out_y, out_pixel_out, out_changed);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_START_X:      sh_sx = val[19:0];
      CFG_START_Y:      sh_sy = val[19:0];
      CFG_END_X:        sh_ex = val[19:0];
      CFG_END_Y:        sh_ey = val[19:0];
      CFG_HALF_WIDTH:   sh_hw = val[15:0];
      CFG_STROKE_RGB:   sh_rgb = val;
      CFG_STROKE_ALPHA: sh_alpha = val[7:0];
      default: ;
    endcase
  endtask

  // sampled at the falling edge so driver and monitor updates have settled
  task automatic drain_pipe();
    while (pending_pixels.size() > 0 || in_valid || expected_blends.size() > 0)
      @(negedge clk);
    repeat (LAT) @(posedge clk);
  endtask

  task automatic line_setup(int sx, int sy, int ex, int ey, int hw, int rgb, int al);
    write_reg(CFG_START_X, 24'(sx)); write_reg(CFG_START_Y, 24'(sy));
    write_reg(CFG_END_X, 24'(ex)); write_reg(CFG_END_Y, 24'(ey));
    write_reg(CFG_HALF_WIDTH, 24'(hw)); write_reg(CFG_STROKE_RGB, 24'(rgb));
    write_reg(CFG_STROKE_ALPHA, 24'(al));
  endtask

  // pixels mostly near the segment so coverage varies
  task automatic near_pixels(int n);
    int lx, hx, ly, hy;
    lx = signed'(sh_sx) >>> FB; hx = signed'(sh_ex) >>> FB;
    ly = signed'(sh_sy) >>> FB; hy = signed'(sh_ey) >>> FB;
    if (lx > hx) begin int s = lx; lx = hx; hx = s; end
    if (ly > hy) begin int s = ly; ly = hy; hy = s; end
    lx = lx < 4 ? 0 : lx - 4; ly = ly < 4 ? 0 : ly - 4;
    hx = hx > 4090 ? 4095 : (hx < 0 ? 8 : hx + 4);
    hy = hy > 4090 ? 4095 : (hy < 0 ? 8 : hy + 4);
    if (lx > 4095) lx = 4000;
    if (ly > 4095) ly = 4000;
    if (hx < lx) hx = lx;
    if (hy < ly) hy = ly;
    repeat (n) begin
      if ($urandom_range(0, 5) == 0)
        pending_pixels.push_back('{x: 12'($urandom), y: 12'($urandom), pix: $urandom});
      else
        pending_pixels.push_back('{x: 12'($urandom_range(lx, hx)),
                                   y: 12'($urandom_range(ly, hy)), pix: $urandom});
    end
  endtask

  initial begin
    sh_sx = 0; sh_sy = 0; sh_ex = 0; sh_ey = 0; sh_hw = 0; sh_rgb = 0; sh_alpha = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;

    // disabled stroke after reset: passthrough, field extremes
    pending_pixels.push_back('{x: 12'h000, y: 12'h000, pix: 32'h0000_0000});
    pending_pixels.push_back('{x: 12'hfff, y: 12'hfff, pix: 32'hffff_ffff});
    drain_pipe();

    // diagonal line, opaque white over assorted pixels, saturated ones included
    line_setup(2560, 2560, 10240, 7680, 512, 24'hffffff, 255);
    pending_pixels.push_back('{x: 12'd10, y: 12'd10, pix: 32'hffff_ffff});
    pending_pixels.push_back('{x: 12'd20, y: 12'd17, pix: 32'h8040_2010});
    pending_pixels.push_back('{x: 12'd5, y: 12'd5, pix: 32'h0000_0000});
    pending_pixels.push_back('{x: 12'd45, y: 12'd35, pix: 32'h1234_5678});
    pending_pixels.push_back('{x: 12'd0, y: 12'd0, pix: 32'hffff_ffff});
    pending_pixels.push_back('{x: 12'd4095, y: 12'd4095, pix: 32'h0});
    pending_pixels.push_back('{x: 12'd11, y: 12'd13, pix: 32'h00ff_00ff});
    drain_pipe();

    // thin width raised to half pixel, low alpha rounding to zero at edges
    line_setup(-524288, 1280, 524287, 1280, 1, 24'h123456, 1);
    pending_pixels.push_back('{x: 12'd100, y: 12'd5, pix: 32'h8080_8080});
    pending_pixels.push_back('{x: 12'd100, y: 12'd6, pix: 32'h8080_8080});
    pending_pixels.push_back('{x: 12'd100, y: 12'd3, pix: 32'h8080_8080});
    drain_pipe();

    // degenerate line and zero width
    line_setup(1000, 1000, 1001, 1000, 65535, 24'hff0000, 200);
    pending_pixels.push_back('{x: 12'd3, y: 12'd3, pix: 32'h1111_1111});
    drain_pipe();
    line_setup(0, 0, 25600, 0, 0, 24'h00ff00, 255);
    pending_pixels.push_back('{x: 12'd50, y: 12'd0, pix: 32'h2222_2222});
    drain_pipe();
    // widest stroke, vertical line at x just under 2048
    line_setup(524287, -524288, 524287, 524287, 65535, 24'h000000, 128);
    pending_pixels.push_back('{x: 12'd4095, y: 12'd4095, pix: 32'hffff_ffff});
    pending_pixels.push_back('{x: 12'd0, y: 12'd2000, pix: 32'hffff_ffff});
    drain_pipe();

    // random segments, mostly within the frame
    for (int ph = 0; ph < 15; ph++) begin
      int sx, sy, ex, ey;
      if (ph % 5 == 4) begin
        sx = $urandom_range(0, 20'hfffff) - 524288; sy = $urandom_range(0, 20'hfffff) - 524288;
        ex = $urandom_range(0, 20'hfffff) - 524288; ey = $urandom_range(0, 20'hfffff) - 524288;
      end else begin
        sx = $urandom_range(0, 64 << FB); sy = $urandom_range(0, 64 << FB);
        ex = $urandom_range(0, 64 << FB); ey = $urandom_range(0, 64 << FB);
      end
      line_setup(sx, sy, ex, ey,
                 (ph % 7 == 3) ? $urandom_range(0, 127) : $urandom_range(0, 2048),
                 $urandom, (ph % 6 == 5) ? 255 : $urandom_range(0, 255));
      near_pixels(30);
      drain_pipe();
    end

    stim_done = 1;
  end

  initial begin
    wait (stim_done || cycles >= LIMIT);
    if (!stim_done) begin
      $display("end of test: mismatches");
      $finish;
    end
    if (errors == 0 && expected_blends.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/alpb_pkg.sv
rtl/alpb_div.sv
rtl/alpb_sqrt.sv
rtl/antialiased_line_pixel_blend.sv
test/tb.sv
